// ----- sv/sltbl_pkg.sv -----
// Shared types and constants for the sorted list table.
package sltbl_pkg;

  localparam int SLTBL_CAPACITY = 16;
  localparam int SLTBL_DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } sltbl_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } sltbl_status_t;

  // Command broadcast to every cell. The shift enables are already
  // qualified by the accept handshake and by the table conditions.
  typedef struct packed {
    logic                           ins;
    logic                           del;
    logic                           pop;
    logic signed [SLTBL_DATA_W-1:0] key;
  } sltbl_cmd_t;

endpackage

// ----- sv/sltbl_cell.sv -----
// One storage cell of the sorted chain, with its compare and shift logic.
module sltbl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                                 clk,
  input  sltbl_pkg::sltbl_cmd_t                cmd,
  input  logic [CNT_W-1:0]                     count,
  input  logic signed [sltbl_pkg::SLTBL_DATA_W-1:0] left_entry,
  input  logic                                 left_ge,
  input  logic signed [sltbl_pkg::SLTBL_DATA_W-1:0] right_entry,
  output logic signed [sltbl_pkg::SLTBL_DATA_W-1:0] entry,
  output logic                                 ge,
  output logic                                 match
);
  import sltbl_pkg::*;

  logic signed [SLTBL_DATA_W-1:0] entry_r;
  logic signed [SLTBL_DATA_W-1:0] entry_nxt;
  logic                           occ;

  assign occ   = CNT_W'(IDX) < count;
  assign ge    = occ && (entry_r >= cmd.key);
  assign match = occ && (entry_r == cmd.key);
  assign entry = entry_r;

  // Insert opens a gap at the first entry not below the key; delete and
  // pop close the gap by pulling from the right-hand neighbor.
  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.ins) begin
      if (left_ge) begin
        entry_nxt = left_entry;
      end else if (ge || !occ) begin
        entry_nxt = cmd.key;
      end
    end else if (cmd.del) begin
      if (ge) begin
        entry_nxt = right_entry;
      end
    end else if (cmd.pop) begin
      entry_nxt = right_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- sv/sorted_list_table_top.sv -----
// Top level of the sorted list table: cell chain, fill counter and result register.
// The table keeps up to CAPACITY signed 32-bit values in ascending order in a row
// of cells, one value per cell. For every word all cells compare their value
// against the key in parallel and each cell then keeps its value, loads the key,
// or takes its left or right neighbor's value, so a new word can be accepted in
// every cycle as long as the result word is taken. Insert places the key
// before any equal values or answers full; search answers ok or not found; delete
// removes one equal entry or answers not found; pop removes and returns the smallest
// value or answers empty with a zero value. Every result word carries the number of
// entries after the operation. The result register sits between the two channels,
// so a waiting result stalls the input only while out_stall is high. No clearing
// pass is needed after reset; only the fill count and the output valid flag are reset.
module sorted_list_table_top #(
  parameter int CAPACITY = sltbl_pkg::SLTBL_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [1:0]                                in_op,
  input  logic signed [sltbl_pkg::SLTBL_DATA_W-1:0] in_key_value,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [1:0]                                out_status,
  output logic signed [sltbl_pkg::SLTBL_DATA_W-1:0] out_result_value,
  output logic [CNT_W-1:0]                          out_entry_count
);
  import sltbl_pkg::*;

  logic signed [SLTBL_DATA_W-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0]            ge_v;
  logic [CAPACITY-1:0]            match_v;

  logic                           accept;
  logic                           found;
  logic                           full;
  logic                           empty;
  sltbl_op_t                      op;
  sltbl_cmd_t                     cmd;

  logic [CNT_W-1:0]               count_r;
  logic [CNT_W-1:0]               count_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  sltbl_status_t                  status_r;
  sltbl_status_t                  status_nxt;
  logic signed [SLTBL_DATA_W-1:0] value_r;
  logic signed [SLTBL_DATA_W-1:0] value_nxt;

  // The input waits only while a finished result is still held downstream.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign op    = sltbl_op_t'(in_op);
  assign found = |match_v;
  assign full  = count_r == CNT_W'(CAPACITY);
  assign empty = count_r == '0;

  // Operation decode: each shift enable is already qualified so that the
  // cells only move data when the table really changes.
  always_comb begin
    cmd.key        = in_key_value;
    cmd.ins        = 1'b0;
    cmd.del        = 1'b0;
    cmd.pop        = 1'b0;
    count_nxt      = count_r;
    status_nxt     = ST_OK;
    value_nxt      = in_key_value;
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins   = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_SEARCH: begin
        status_nxt = found ? ST_OK : ST_NOT_FOUND;
      end
      OP_DELETE: begin
        if (found) begin
          cmd.del   = accept;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      OP_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
          value_nxt  = '0;
        end else begin
          cmd.pop   = accept;
          value_nxt = ent[0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // The cell row. The first cell has no left neighbor; the last cell pulls
  // its own value, which only lands in the unused part of the table.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sltbl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count_r),
      .left_entry  ((i == 0) ? in_key_value : ent[(i == 0) ? 0 : i - 1]),
      .left_ge     ((i == 0) ? 1'b0 : ge_v[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == CAPACITY - 1) ? ent[i] : ent[(i == CAPACITY - 1) ? i : i + 1]),
      .entry       (ent[i]),
      .ge          (ge_v[i]),
      .match       (match_v[i])
    );
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload is loaded on accept and otherwise holds.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_result_value = value_r;
  assign out_entry_count  = count_r;

  // The fill count never passes the table size.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // A rejected insert leaves the table size alone and reports full.
  a_full_reject : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_INSERT && full) |=> ($stable(count_r) && status_r == ST_FULL))
    else $error("insert into full table changed the count");

  // A pop on an empty table reports empty with a zero value.
  a_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_POP && empty) |=> (status_r == ST_EMPTY && value_r == '0))
    else $error("pop on empty table gave a wrong result");

  // Successful delete and pop shrink the table by exactly one.
  a_shrink : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((op == OP_DELETE && found) || (op == OP_POP && !empty)))
      |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("removal did not shrink the table by one");

endmodule
